FILE: src/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// Shared constants, operation codes and the command and status bundles
// that join the xxHash64 controller and datapath.
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

    localparam int ROT_ROUND = 31;
    localparam int ROT_LONG  = 27;
    localparam int ROT_WORD  = 23;
    localparam int ROT_BYTE  = 11;
    localparam int AV_SHIFT1 = 33;
    localparam int AV_SHIFT2 = 29;
    localparam int AV_SHIFT3 = 32;

    localparam logic [3:0] FULL_WORD = 4'd8;
    localparam logic [3:0] HALF_WORD = 4'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INIT,
        OP_RND_A,
        OP_RND_B,
        OP_CONV,
        OP_MRG_A,
        OP_MRG_B,
        OP_MRG_C,
        OP_ADDLEN,
        OP_TL_A,
        OP_TL_B,
        OP_TL_C,
        OP_W4_A,
        OP_W4_B,
        OP_B_A,
        OP_B_B,
        OP_AV_A,
        OP_AV_B,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic mul_start;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic full;
        logic seen;
        logic idx_last;
        logic buf_more;
        logic part_ge4;
        logic part_nz;
        logic out_free;
        logic mul_busy;
        logic mul_done;
    } sts_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
        rotl64 = (v << r) | (v >> (64 - r));
    endfunction

endpackage

FILE: src/xxh_mul.sv
// ----------------------------------------------------------------------------
// xxh_mul
// Iterative 64x64 multiplier returning the low 64 bits of the product,
// built from one 32x32 multiplier over three partial-product passes.
// ----------------------------------------------------------------------------
module xxh_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic        done,
    output logic [63:0] result
);
    import xxh_pkg::*;

    typedef enum logic [1:0] {PH_LL, PH_LH, PH_HL} phase_t;

    phase_t      phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] x, y;
    logic [63:0] prod;

    always_comb
    begin
        unique case (phase_reg)
            PH_LL:   begin x = a_reg[31:0];  y = b_reg[31:0];  end
            PH_LH:   begin x = a_reg[31:0];  y = b_reg[63:32]; end
            PH_HL:   begin x = a_reg[63:32]; y = b_reg[31:0];  end
            default: begin x = a_reg[31:0];  y = b_reg[31:0];  end
        endcase
        prod = {32'd0, x} * {32'd0, y};
    end

    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            a_next     = a;
            b_next     = b;
            busy_next  = 1'b1;
            phase_next = PH_LL;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                PH_LL:
                begin
                    acc_next   = prod;
                    phase_next = PH_LH;
                end
                PH_LH:
                begin
                    acc_next   = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                    phase_next = PH_HL;
                end
                default:
                begin
                    acc_next   = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                    phase_next = PH_LL;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LL;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

FILE: src/xxh_dp.sv
// ----------------------------------------------------------------------------
// xxh_dp
// Datapath: seed, lane accumulators, stripe buffer, length counter, hash
// accumulator and output register, stepped by controller commands.
// ----------------------------------------------------------------------------
module xxh_dp
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  xxh_pkg::cmd_t cmd,
    output xxh_pkg::sts_t sts,
    input  logic          in_valid,
    input  logic [63:0]   data_word,
    input  logic [3:0]    byte_count,
    input  logic          last,
    input  logic          cfg_valid,
    input  logic [63:0]   seed,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   hash_value
);
    import xxh_pkg::*;

    logic [63:0]            seed_reg, seed_next;
    logic [63:0]            lane_reg [4];
    logic [63:0]            lane_next [4];
    logic [63:0]            buf_reg [4];
    logic [63:0]            buf_next [4];
    logic [2:0]             fill_reg, fill_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   seen_reg, seen_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   last_reg, last_next;
    logic                   full_reg, full_next;
    logic [3:0]             part_reg, part_next;
    logic [63:0]            word_reg, word_next;
    logic [63:0]            h_reg, h_next;
    logic [63:0]            t_reg, t_next;
    logic                   oval_reg, oval_next;
    logic [63:0]            hash_reg, hash_next;

    logic [3:0]  cnt_eff;
    logic [63:0] mul_a, mul_b, mul_r;
    logic        mul_busy, mul_done;
    logic        out_free;

    assign out_free = !oval_reg || out_ready;
    assign cnt_eff  = (!last || byte_count > FULL_WORD) ? FULL_WORD : byte_count;

    always_comb
    begin
        unique case (cmd.op)
            OP_RND_A: begin mul_a = buf_reg[idx_reg];            mul_b = PRIME2; end
            OP_RND_B: begin mul_a = t_reg;                       mul_b = PRIME1; end
            OP_MRG_A: begin mul_a = lane_reg[idx_reg];           mul_b = PRIME2; end
            OP_MRG_B: begin mul_a = t_reg;                       mul_b = PRIME1; end
            OP_MRG_C: begin mul_a = h_reg;                       mul_b = PRIME1; end
            OP_TL_A:  begin mul_a = buf_reg[idx_reg];            mul_b = PRIME2; end
            OP_TL_B:  begin mul_a = t_reg;                       mul_b = PRIME1; end
            OP_TL_C:  begin mul_a = rotl64(h_reg, ROT_LONG);     mul_b = PRIME1; end
            OP_W4_A:  begin mul_a = {32'd0, word_reg[31:0]};     mul_b = PRIME1; end
            OP_W4_B:  begin mul_a = rotl64(h_reg, ROT_WORD);     mul_b = PRIME2; end
            OP_B_A:   begin mul_a = {56'd0, word_reg[7:0]};      mul_b = PRIME5; end
            OP_B_B:   begin mul_a = rotl64(h_reg, ROT_BYTE);     mul_b = PRIME1; end
            OP_AV_A:  begin mul_a = h_reg ^ (h_reg >> AV_SHIFT1); mul_b = PRIME2; end
            OP_AV_B:  begin mul_a = h_reg ^ (h_reg >> AV_SHIFT2); mul_b = PRIME3; end
            default:  begin mul_a = h_reg;                       mul_b = PRIME1; end
        endcase
    end

    xxh_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_r)
    );

    always_comb
    begin
        seed_next = cfg_valid ? seed : seed_reg;
        lane_next = lane_reg;
        buf_next  = buf_reg;
        fill_next = fill_reg;
        len_next  = len_reg;
        seen_next = seen_reg;
        idx_next  = idx_reg;
        last_next = last_reg;
        full_next = full_reg;
        part_next = part_reg;
        word_next = word_reg;
        h_next    = h_reg;
        t_next    = t_reg;
        oval_next = oval_reg && !out_ready;
        hash_next = hash_reg;

        unique case (cmd.op)
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    len_next  = len_reg + LENGTH_BITS'(cnt_eff);
                    word_next = data_word;
                    last_next = last;
                    full_next = (cnt_eff == FULL_WORD) && (fill_reg == 3'd3);
                    part_next = (cnt_eff == FULL_WORD) ? 4'd0 : cnt_eff;
                    if (cnt_eff == FULL_WORD)
                    begin
                        buf_next[fill_reg[1:0]] = data_word;
                        fill_next = fill_reg + 3'd1;
                    end
                end
            end
            OP_INIT:
            begin
                if (!seen_reg)
                begin
                    lane_next[0] = seed_reg + PRIME1 + PRIME2;
                    lane_next[1] = seed_reg + PRIME2;
                    lane_next[2] = seed_reg;
                    lane_next[3] = seed_reg - PRIME1;
                end
                idx_next = 2'd0;
            end
            OP_RND_A:
            begin
                if (mul_done)
                    t_next = rotl64(lane_reg[idx_reg] + mul_r, ROT_ROUND);
            end
            OP_RND_B:
            begin
                if (mul_done)
                begin
                    lane_next[idx_reg] = mul_r;
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        seen_next = 1'b1;
                        fill_next = 3'd0;
                    end
                end
            end
            OP_CONV:
            begin
                if (seen_reg)
                    h_next = rotl64(lane_reg[0], 1) + rotl64(lane_reg[1], 7)
                           + rotl64(lane_reg[2], 12) + rotl64(lane_reg[3], 18);
                else
                    h_next = seed_reg + PRIME5;
                idx_next = 2'd0;
            end
            OP_MRG_A, OP_TL_A:
            begin
                if (mul_done)
                    t_next = rotl64(mul_r, ROT_ROUND);
            end
            OP_MRG_B, OP_TL_B, OP_W4_A, OP_B_A:
            begin
                if (mul_done)
                    h_next = h_reg ^ mul_r;
            end
            OP_MRG_C, OP_TL_C:
            begin
                if (mul_done)
                begin
                    h_next   = mul_r + PRIME4;
                    idx_next = idx_reg + 2'd1;
                end
            end
            OP_ADDLEN:
            begin
                h_next   = h_reg + 64'(len_reg);
                idx_next = 2'd0;
            end
            OP_W4_B:
            begin
                if (mul_done)
                begin
                    h_next    = mul_r + PRIME3;
                    word_next = word_reg >> 32;
                    part_next = part_reg - HALF_WORD;
                end
            end
            OP_B_B:
            begin
                if (mul_done)
                begin
                    h_next    = mul_r;
                    word_next = word_reg >> 8;
                    part_next = part_reg - 4'd1;
                end
            end
            OP_AV_A, OP_AV_B:
            begin
                if (mul_done)
                    h_next = mul_r;
            end
            OP_DONE:
            begin
                if (out_free)
                begin
                    hash_next = h_reg ^ (h_reg >> AV_SHIFT3);
                    oval_next = 1'b1;
                    fill_next = 3'd0;
                    len_next  = '0;
                    seen_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            fill_reg <= '0;
            len_reg  <= '0;
            seen_reg <= 1'b0;
            idx_reg  <= '0;
            last_reg <= 1'b0;
            full_reg <= 1'b0;
            part_reg <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            seed_reg <= seed_next;
            fill_reg <= fill_next;
            len_reg  <= len_next;
            seen_reg <= seen_next;
            idx_reg  <= idx_next;
            last_reg <= last_next;
            full_reg <= full_next;
            part_reg <= part_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
        buf_reg  <= buf_next;
        word_reg <= word_next;
        h_reg    <= h_next;
        t_reg    <= t_next;
        hash_reg <= hash_next;
    end

    always_comb
    begin
        sts.last     = last_reg;
        sts.full     = full_reg;
        sts.seen     = seen_reg;
        sts.idx_last = (idx_reg == 2'd3);
        sts.buf_more = ({1'b0, idx_reg} < fill_reg);
        sts.part_ge4 = (part_reg >= HALF_WORD);
        sts.part_nz  = (part_reg != 4'd0);
        sts.out_free = out_free;
        sts.mul_busy = mul_busy;
        sts.mul_done = mul_done;
    end

    assign out_valid  = oval_reg;
    assign hash_value = hash_reg;

endmodule

FILE: src/xxh_ctrl.sv
// ----------------------------------------------------------------------------
// xxh_ctrl
// Controller: sequences word intake, stripe rounds, lane convergence,
// tail folding and avalanche over the shared multiplier.
// ----------------------------------------------------------------------------
module xxh_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  xxh_pkg::sts_t sts,
    output xxh_pkg::cmd_t cmd
);
    import xxh_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_INIT, S_RND_A, S_RND_B, S_CONV,
        S_MRG_A, S_MRG_B, S_MRG_C, S_ADDLEN, S_TL_CHK, S_TL_A, S_TL_B, S_TL_C,
        S_W4_CHK, S_W4_A, S_W4_B, S_B_CHK, S_B_A, S_B_B, S_AV_A, S_AV_B, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   wait_reg, wait_next;
    logic   is_mul;
    op_t    op;

    always_comb
    begin
        is_mul = 1'b1;
        unique case (state_reg)
            S_RND_A: op = OP_RND_A;
            S_RND_B: op = OP_RND_B;
            S_MRG_A: op = OP_MRG_A;
            S_MRG_B: op = OP_MRG_B;
            S_MRG_C: op = OP_MRG_C;
            S_TL_A:  op = OP_TL_A;
            S_TL_B:  op = OP_TL_B;
            S_TL_C:  op = OP_TL_C;
            S_W4_A:  op = OP_W4_A;
            S_W4_B:  op = OP_W4_B;
            S_B_A:   op = OP_B_A;
            S_B_B:   op = OP_B_B;
            S_AV_A:  op = OP_AV_A;
            S_AV_B:  op = OP_AV_B;
            S_IDLE:  begin op = OP_ACCEPT; is_mul = 1'b0; end
            S_INIT:  begin op = OP_INIT;   is_mul = 1'b0; end
            S_CONV:  begin op = OP_CONV;   is_mul = 1'b0; end
            S_ADDLEN: begin op = OP_ADDLEN; is_mul = 1'b0; end
            S_DONE:  begin op = OP_DONE;   is_mul = 1'b0; end
            default: begin op = OP_NONE;   is_mul = 1'b0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        if (is_mul)
        begin
            if (!wait_reg)
                wait_next = 1'b1;
            else if (sts.mul_done)
            begin
                wait_next = 1'b0;
                unique case (state_reg)
                    S_RND_A: state_next = S_RND_B;
                    S_RND_B: state_next = !sts.idx_last ? S_RND_A
                                        : (sts.last ? S_CONV : S_IDLE);
                    S_MRG_A: state_next = S_MRG_B;
                    S_MRG_B: state_next = S_MRG_C;
                    S_MRG_C: state_next = sts.idx_last ? S_ADDLEN : S_MRG_A;
                    S_TL_A:  state_next = S_TL_B;
                    S_TL_B:  state_next = S_TL_C;
                    S_TL_C:  state_next = S_TL_CHK;
                    S_W4_A:  state_next = S_W4_B;
                    S_W4_B:  state_next = S_B_CHK;
                    S_B_A:   state_next = S_B_B;
                    S_B_B:   state_next = S_B_CHK;
                    S_AV_A:  state_next = S_AV_B;
                    default: state_next = S_DONE;
                endcase
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:   if (in_valid) state_next = S_CHECK;
                S_CHECK:  state_next = sts.full ? S_INIT : (sts.last ? S_CONV : S_IDLE);
                S_INIT:   state_next = S_RND_A;
                S_CONV:   state_next = sts.seen ? S_MRG_A : S_ADDLEN;
                S_ADDLEN: state_next = S_TL_CHK;
                S_TL_CHK: state_next = sts.buf_more ? S_TL_A : S_W4_CHK;
                S_W4_CHK: state_next = sts.part_ge4 ? S_W4_A : S_B_CHK;
                S_B_CHK:  state_next = sts.part_nz ? S_B_A : S_AV_A;
                S_DONE:   if (sts.out_free) state_next = S_IDLE;
                default:  state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign cmd.op        = op;
    assign cmd.mul_start = is_mul && !wait_reg;

endmodule

FILE: src/xxhash64_stream.sv
// ----------------------------------------------------------------------------
// xxhash64_stream
// Streaming 64-bit xxHash over little-endian words with a seed register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   input    | in_valid / in_ready  | data_word, byte_count, last
//   output   | out_valid / out_ready| hash_value
//   config   | cfg_valid / cfg_ready| seed
//
// A word that leaves the stripe open is only buffered. A word that closes a
// stripe loads the lanes if none was seen, then runs eight multiplies on
// one shared multiplier, itself three passes of a 32x32 unit. Finish merges
// the lanes (stripe seen), adds the length, folds each buffered word, four
// tail bytes and each single byte, then avalanches. Reset returns seed to
// zero and the block to idle; a held output waits in its register until taken.
// ----------------------------------------------------------------------------
module xxhash64_stream
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] seed
);
    import xxh_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    xxh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    xxh_dp #(.LENGTH_BITS(LENGTH_BITS)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_valid   (in_valid),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .seed       (seed),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !sts.mul_busy)
        else $error("multiply started while busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.mul_busy)
        else $error("input open while multiply runs");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken before first processed");

endmodule

FILE: tb/xxhash64_stream_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xxhash64_stream_check
// Watches the seed, word and hash channels of xxhash64_stream. Keeps its own
// model of the lanes, stripe buffer and length, predicts the hash of each
// finished message and compares it with the hash the block returns.
// ----------------------------------------------------------------------------
module xxhash64_stream_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] hash_value,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [63:0] seed,
    output int          errors,
    output int          hashes_pending,
    output int          hashes_seen
);

    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;

    logic [63:0] seed_reg;
    logic [63:0] lanes [4];
    logic [63:0] stripe [4];
    logic [2:0]  fill;
    logic [63:0] msg_len;
    logic        had_stripe;
    logic [63:0] hash_q [$];

    function automatic logic [63:0] rol(input logic [63:0] v, input int r);
        return (r == 0) ? v : ((v << r) | (v >> (64 - r)));
    endfunction

    function automatic logic [63:0] round64(input logic [63:0] acc, input logic [63:0] w);
        return rol(acc + w * P2, 31) * P1;
    endfunction

    task automatic start_lanes();
        lanes[0] = seed_reg + P1 + P2;
        lanes[1] = seed_reg + P2;
        lanes[2] = seed_reg;
        lanes[3] = seed_reg - P1;
    endtask

    task automatic absorb_word(input logic [63:0] w, input logic [3:0] cnt_in,
                               input logic fin);
        int          cnt;
        int          part;
        logic [63:0] h;
        logic [63:0] wd;
        cnt = (cnt_in > 8 || !fin) ? 8 : cnt_in;
        part = 0;
        wd = w;
        msg_len = msg_len + cnt;
        if (cnt == 8) begin
            stripe[fill[1:0]] = w;
            fill = fill + 3'd1;
            if (fill >= 4) begin
                if (!had_stripe)
                    start_lanes();
                for (int i = 0; i < 4; i++)
                    lanes[i] = round64(lanes[i], stripe[i]);
                had_stripe = 1;
                fill = 0;
            end
        end
        else
            part = cnt;
        if (!fin)
            return;
        if (had_stripe) begin
            h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
            for (int i = 0; i < 4; i++)
                h = ((h ^ round64(64'd0, lanes[i])) * P1) + P4;
        end
        else
            h = seed_reg + P5;
        h = h + msg_len;
        for (int i = 0; i < fill && i < 4; i++) begin
            h = h ^ round64(64'd0, stripe[i]);
            h = rol(h, 27) * P1 + P4;
        end
        if (part >= 4) begin
            h = h ^ ({32'd0, wd[31:0]} * P1);
            h = rol(h, 23) * P2 + P3;
            wd = wd >> 32;
            part = part - 4;
        end
        while (part > 0) begin
            h = h ^ ({56'd0, wd[7:0]} * P5);
            h = rol(h, 11) * P1;
            wd = wd >> 8;
            part--;
        end
        h = h ^ (h >> 33);
        h = h * P2;
        h = h ^ (h >> 29);
        h = h * P3;
        h = h ^ (h >> 32);
        hash_q.push_back(h);
        start_lanes();
        fill = 0;
        msg_len = 0;
        had_stripe = 0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seed_reg = 64'd0;
            start_lanes();
            fill = 0;
            msg_len = 0;
            had_stripe = 0;
            hash_q.delete();
            errors = 0;
            hashes_seen = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                hashes_seen++;
                if (hash_q.size() == 0) begin
                    errors++;
                    $error("hash_value: expected none, actual %h", hash_value);
                end
                else if (hash_q[0] !== hash_value) begin
                    errors++;
                    $error("hash_value: expected %h, actual %h", hash_q[0], hash_value);
                    void'(hash_q.pop_front());
                end
                else
                    void'(hash_q.pop_front());
            end
            if (cfg_valid && cfg_ready)
                seed_reg = seed;
            if (in_valid && in_ready)
                absorb_word(data_word, byte_count, last);
        end
        hashes_pending = hash_q.size();
    end

endmodule

FILE: tb/xxhash64_stream_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xxhash64_stream_test
// Drives xxhash64_stream with directed and random messages under several
// seeds and idle patterns on both sides; the checker beside the block
// predicts and compares every hash.
// ----------------------------------------------------------------------------
module xxhash64_stream_test;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] hash_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] seed;
    int          errors;
    int          hashes_pending;
    int          hashes_seen;
    int          send_idle;
    int          recv_idle;
    int          words_sent;
    int          messages_sent;

    xxhash64_stream i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .seed       (seed)
    );

    xxhash64_stream_check i_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .seed           (seed),
        .errors         (errors),
        .hashes_pending (hashes_pending),
        .hashes_seen    (hashes_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        out_ready = rst_n && ($urandom_range(0, 99) >= recv_idle);

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
        if ($urandom_range(0, 99) < send_idle) begin
            in_valid = 1'b0;
            while ($urandom_range(0, 99) < send_idle)
                @(negedge clk);
            @(negedge clk);
        end
        in_valid = 1'b1;
        data_word = w;
        byte_count = cnt;
        last = fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (fin)
            messages_sent++;
    endtask

    task automatic send_message(input int body_words, input logic [3:0] tail_cnt,
                                input logic [63:0] fixed, input logic use_fixed);
        for (int i = 0; i < body_words; i++)
            send_word(use_fixed ? fixed : rand64(), 4'($urandom_range(0, 15)), 1'b0);
        send_word(use_fixed ? fixed : rand64(), tail_cnt, 1'b1);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        @(negedge clk);
        while (hashes_pending != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        drain();
        cfg_valid = 1'b1;
        seed = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_phase(input int words, input int s_idle, input int r_idle);
        int n;
        send_idle = s_idle;
        recv_idle = r_idle;
        n = 0;
        while (n < words) begin
            int body;
            body = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 9);
            send_message(body, 4'($urandom_range(0, 15)), 64'd0, 1'b0);
            n += body + 1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_word = '0;
        byte_count = '0;
        last = 1'b0;
        cfg_valid = 1'b0;
        seed = '0;
        send_idle = 0;
        recv_idle = 0;
        words_sent = 0;
        messages_sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_message(0, 4'd0, 64'd0, 1'b1);
        for (int c = 1; c <= 8; c++)
            send_message(0, 4'(c), 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_message(0, 4'd15, 64'd0, 1'b1);
        send_message(3, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_message(4, 4'd7, 64'd0, 1'b1);
        send_message(7, 4'd0, 64'h0123_4567_89AB_CDEF, 1'b0);
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_message(0, 4'd0, 64'd0, 1'b1);
        send_message(4, 4'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        write_seed(64'd0);

        random_phase(650, 24, 76);
        write_seed(rand64());
        random_phase(650, 76, 24);
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(650, 0, 0);
        drain();

        $display("Sent %0d words in %0d messages, %0d hashes checked, seeds 0, ~0 and random",
                 words_sent, messages_sent, hashes_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d hashes outstanding", hashes_pending);
        $display("Mismatches found");
        $finish;
    end

endmodule
